>>> rtl/cabv_pkg.sv
// cabv_pkg: shared types and constants for the clockwise angle block.
// Word formats, CORDIC arctangent table and fixed-point widths.
// No dependencies.
`default_nettype none

package cabv_pkg;

	localparam int COORD_W  = 16;
	localparam int ANGLE_W  = 16;
	localparam int ITER_DEF = 16;
	localparam int ITER_MAX = 32;
	localparam int ACC_W    = 32;
	localparam int NORM_EXP = 40;
	localparam int DATA_W   = NORM_EXP + 5;
	localparam int SHIFT_W  = $clog2(NORM_EXP + 1);
	localparam int DROP     = ACC_W - ANGLE_W;

	typedef logic [ACC_W-1:0] acc_t;

	localparam acc_t HALF_TURN = acc_t'(1) << (ACC_W - 1);
	localparam acc_t RND_HALF  = acc_t'(1) << (DROP - 1);

	// atan(2^-i), 2^32 = full turn
	localparam acc_t ATAN_TAB [ITER_MAX] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] ref_x;
		logic signed [COORD_W-1:0] ref_y;
		logic signed [COORD_W-1:0] other_x;
		logic signed [COORD_W-1:0] other_y;
	} cabv_in_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_turn;
		logic               degenerate;
	} cabv_out_t;

endpackage

`default_nettype wire

>>> rtl/clockwise_angle_between_vectors.sv
// clockwise_angle_between_vectors: pipelined CORDIC vectoring of two vectors
// and the wrapped difference of their directions. Depends on cabv_pkg.
//
// Usage:
//   vec (valid/ready) carries one word: reference and second vector, signed.
//   angle (valid/ready) returns one word per input: the clockwise angle from
//   the reference to the second vector (2^16 = full turn) and a degenerate
//   flag, set with angle 0 when either vector is (0,0).
//   Pipeline: abs/max, lead-one detect, normalize, one CORDIC stage per
//   iteration, then subtract and round into the output register.
//   Throughput: one word per cycle while the skid is empty; every stage
//   holds its own word.
//   Stall: the output register is backed by a one-word skid buffer; the
//   pipeline keeps moving while the skid is empty, so input is still taken
//   while a finished word waits. vec_ready drops only while the skid is full.
//   Reset: arst_n clears all valid bits; no words are held after reset.
`default_nettype none

module clockwise_angle_between_vectors
	import cabv_pkg::*;
#(
	parameter int ITERATIONS = ITER_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vec_valid,
	output logic      vec_ready,
	input  cabv_in_t  vec,
	output logic      angle_valid,
	input  logic      angle_ready,
	output cabv_out_t angle
);

	localparam int CS   = 3;
	localparam int LAST = ITERATIONS + CS;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DATA_W-1:0]  data_t;

	logic                 en;
	logic [LAST:1]        vld_s;
	logic [LAST:1]        deg_s;

	coord_t               in_x [2];
	coord_t               in_y [2];
	logic [COORD_W-1:0]   ax [2];
	logic [COORD_W-1:0]   ay [2];
	logic                 deg_in;

	coord_t               x_s1 [2];
	coord_t               y_s1 [2];
	logic [COORD_W-1:0]   m_s1 [2];

	coord_t               x_s2 [2];
	coord_t               y_s2 [2];
	logic [SHIFT_W-1:0]   sh_s2 [2];
	logic [SHIFT_W-1:0]   pos [2];

	data_t                xw [2];
	data_t                yw [2];

	data_t                cx_s [CS:LAST][2];
	data_t                cy_s [CS:LAST][2];
	acc_t                 cz_s [CS:LAST][2];

	acc_t                 diff;
	acc_t                 rnd;
	cabv_out_t            res;
	logic                 push;
	logic                 pop;

	cabv_out_t            out_q;
	logic                 out_vld_q;
	cabv_out_t            skid_q;
	logic                 skid_vld_q;

	assign en        = !skid_vld_q;
	assign vec_ready = en;

	// Stage 1: magnitudes and max
	always_comb begin
		in_x[0] = vec.ref_x;
		in_y[0] = vec.ref_y;
		in_x[1] = vec.other_x;
		in_y[1] = vec.other_y;
		for (int v = 0; v < 2; v++) begin
			ax[v] = in_x[v][COORD_W-1] ? (~in_x[v] + 1'b1) : in_x[v];
			ay[v] = in_y[v][COORD_W-1] ? (~in_y[v] + 1'b1) : in_y[v];
		end
		deg_in = ((vec.ref_x == '0) && (vec.ref_y == '0)) ||
			((vec.other_x == '0) && (vec.other_y == '0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				x_s1[v] <= in_x[v];
				y_s1[v] <= in_y[v];
				m_s1[v] <= (ax[v] > ay[v]) ? ax[v] : ay[v];
			end
		end
	end

	// Stage 2: lead-one position gives the normalizing shift
	always_comb begin
		for (int v = 0; v < 2; v++) begin
			pos[v] = '0;
			for (int b = 0; b < COORD_W; b++) begin
				if (m_s1[v][b]) begin
					pos[v] = SHIFT_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				x_s2[v]  <= x_s1[v];
				y_s2[v]  <= y_s1[v];
				sh_s2[v] <= SHIFT_W'(NORM_EXP) - pos[v];
			end
		end
	end

	// Stage 3: normalize, fold left half-plane
	always_comb begin
		for (int v = 0; v < 2; v++) begin
			xw[v] = data_t'(x_s2[v]) <<< sh_s2[v];
			yw[v] = data_t'(y_s2[v]) <<< sh_s2[v];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				if (x_s2[v][COORD_W-1]) begin
					cx_s[CS][v] <= -xw[v];
					cy_s[CS][v] <= -yw[v];
					cz_s[CS][v] <= HALF_TURN;
				end else begin
					cx_s[CS][v] <= xw[v];
					cy_s[CS][v] <= yw[v];
					cz_s[CS][v] <= '0;
				end
			end
		end
	end

	// CORDIC vectoring, one iteration per stage
	for (genvar k = CS + 1; k <= LAST; k++) begin : g_iter
		localparam int I = k - CS - 1;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int v = 0; v < 2; v++) begin
					if (!cy_s[k-1][v][DATA_W-1]) begin
						cx_s[k][v] <= cx_s[k-1][v] + (cy_s[k-1][v] >>> I);
						cy_s[k][v] <= cy_s[k-1][v] - (cx_s[k-1][v] >>> I);
						cz_s[k][v] <= cz_s[k-1][v] + ATAN_TAB[I];
					end else begin
						cx_s[k][v] <= cx_s[k-1][v] - (cy_s[k-1][v] >>> I);
						cy_s[k][v] <= cy_s[k-1][v] + (cx_s[k-1][v] >>> I);
						cz_s[k][v] <= cz_s[k-1][v] - ATAN_TAB[I];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], vec_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s <= {deg_s[LAST-1:1], deg_in};
		end
	end

	// Difference of directions, rounded half up, wraps at a full turn
	always_comb begin
		diff             = cz_s[LAST][0] - cz_s[LAST][1];
		rnd              = diff + RND_HALF;
		res.degenerate   = deg_s[LAST];
		res.angle_turn   = deg_s[LAST] ? '0 : rnd[ACC_W-1 -: ANGLE_W];
	end

	assign push = en && vld_s[LAST];
	assign pop  = out_vld_q && angle_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || pop) begin
				out_vld_q  <= skid_vld_q || push;
				skid_vld_q <= 1'b0;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign angle_valid = out_vld_q;
	assign angle       = out_q;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held with empty output register");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !angle_ready))
		else $error("skid filled without an output stall");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !angle_ready) |=> (skid_vld_q && $stable(skid_q)))
		else $error("skid word lost during stall");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_valid && angle.degenerate) |-> (angle.angle_turn == '0))
		else $error("degenerate word with nonzero angle");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_clockwise_angle_between_vectors.sv
// tb_clockwise_angle_between_vectors: self-checking bench for the clockwise angle block.
// Predicts each result with a CORDIC model and compares every word. Random idle/stall phases.
// Depends on cabv_pkg and clockwise_angle_between_vectors.
module tb_clockwise_angle_between_vectors
	import cabv_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CORDIC_STAGES = 16;
	localparam int  DRAIN_CYCLES  = 40;
	localparam real RUN_LIMIT_NS  = 5.0e6;

	localparam logic [31:0] ATAN_LUT [CORDIC_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861
	};

	typedef struct {
		cabv_in_t  src;
		cabv_out_t want;
	} angle_check_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      vec_valid = 1'b0;
	logic      vec_ready;
	cabv_in_t  vec = '0;
	logic      angle_valid;
	logic      angle_ready = 1'b0;
	cabv_out_t angle;

	angle_check_t expected_angles [$];
	int           mismatch_count = 0;
	int           send_gap_pct = 0;
	int           recv_stall_pct = 0;

	clockwise_angle_between_vectors #(.ITERATIONS(CORDIC_STAGES)) uut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
		.angle_valid(angle_valid), .angle_ready(angle_ready), .angle(angle)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// direction of a nonzero vector, 2^32 = full turn
	function automatic logic [31:0] vector_heading(longint x, longint y);
		longint          xs, ys;
		longint unsigned m, ax, ay;
		int              sh;
		logic [31:0]     z;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		m  = (ax > ay) ? ax : ay;
		sh = 0;
		while (m < (64'd1 << 40) && sh < 40) begin
			m = m << 1;
			sh++;
		end
		x = x <<< sh;
		y = y <<< sh;
		z = 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_LUT[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_LUT[i];
			end
		end
		return z;
	endfunction

	function automatic cabv_out_t predict_angle(cabv_in_t w);
		cabv_out_t   r;
		logic [31:0] d;
		logic [32:0] rounded;
		r = '0;
		if ((w.ref_x == 0 && w.ref_y == 0) || (w.other_x == 0 && w.other_y == 0)) begin
			r.degenerate = 1'b1;
			return r;
		end
		d = vector_heading(w.ref_x, w.ref_y) - vector_heading(w.other_x, w.other_y);
		rounded = {1'b0, d} + (33'd1 << (32 - ANGLE_W - 1));
		r.angle_turn = rounded[31 -: ANGLE_W];
		return r;
	endfunction

	function automatic cabv_in_t vec_pair(int rx, int ry, int ox, int oy);
		cabv_in_t w;
		w.ref_x   = rx[COORD_W-1:0];
		w.ref_y   = ry[COORD_W-1:0];
		w.other_x = ox[COORD_W-1:0];
		w.other_y = oy[COORD_W-1:0];
		return w;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: begin
				case ($urandom_range(4))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			1: return COORD_W'($signed($urandom_range(16)) - 8);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic cabv_in_t rand_pair();
		cabv_in_t w;
		int       k;
		w.ref_x   = rand_coord();
		w.ref_y   = rand_coord();
		w.other_x = rand_coord();
		w.other_y = rand_coord();
		k = $urandom_range(6);
		case ($urandom_range(9))
			0: begin
				w.other_x = w.ref_x >>> k;
				w.other_y = w.ref_y >>> k;
			end
			1: begin
				w.other_x = -(w.ref_x >>> k);
				w.other_y = -(w.ref_y >>> k);
			end
			2: begin
				if ($urandom_range(1)) begin
					w.ref_x = '0;
					w.ref_y = '0;
				end else begin
					w.other_x = '0;
					w.other_y = '0;
				end
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_word(cabv_in_t w);
		angle_check_t c;
		while ($urandom_range(99) < send_gap_pct) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= w;
		@(posedge clk);
		while (!vec_ready)
			@(posedge clk);
		c.src  = w;
		c.want = predict_angle(w);
		expected_angles.push_back(c);
	endtask

	task automatic idle_sender();
		vec_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		cabv_in_t words [$];
		words.push_back(vec_pair(0, 0, 0, 0));
		words.push_back(vec_pair(0, 0, 5, -7));
		words.push_back(vec_pair(-3, 9, 0, 0));
		words.push_back(vec_pair(1, 0, 1, 0));
		words.push_back(vec_pair(1, 0, 0, 1));
		words.push_back(vec_pair(1, 0, 0, -1));
		words.push_back(vec_pair(1, 0, -1, 0));
		words.push_back(vec_pair(32767, 0, -32768, 0));
		words.push_back(vec_pair(-32768, -32768, 32767, 32767));
		words.push_back(vec_pair(-32768, 0, 1, 0));
		words.push_back(vec_pair(0, -32768, 0, 32767));
		words.push_back(vec_pair(-1, -1, 1, 1));
		words.push_back(vec_pair(32767, 32767, 1, 1));
		words.push_back(vec_pair(-32768, 32767, 32767, -32768));
		words.push_back(vec_pair(-5, 3, -5, -3));
		words.push_back(vec_pair(0, 1, -1, 0));
		words.push_back(vec_pair(100, -1, 100, 1));
		words.push_back(vec_pair(-32768, -1, -32768, 1));
		words.push_back(vec_pair(1, -32768, -1, -32768));
		words.push_back(vec_pair(-7, -7, -7, -7));
		foreach (words[i])
			send_word(words[i]);
	endtask

	task automatic test_random_pairs(int gap_pct, int stall_pct, int count);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_word(rand_pair());
	endtask

	// sender holds off until the pipe is empty, then resumes back-to-back
	task automatic test_drain_pause();
		send_gap_pct   = 0;
		recv_stall_pct = 13;
		repeat (20)
			send_word(rand_pair());
		vec_valid <= 1'b0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (20)
			send_word(rand_pair());
	endtask

	always @(posedge clk) begin : check_results
		angle_check_t c;
		if (arst_n && angle_valid && angle_ready) begin
			if (expected_angles.size() == 0) begin
				report_mismatch($sformatf("unexpected word angle=%0d degenerate=%0b",
					angle.angle_turn, angle.degenerate));
			end else begin
				c = expected_angles.pop_front();
				if (angle.angle_turn !== c.want.angle_turn)
					report_mismatch($sformatf("angle %0d want %0d for (%0d,%0d)->(%0d,%0d)",
						angle.angle_turn, c.want.angle_turn, c.src.ref_x, c.src.ref_y,
						c.src.other_x, c.src.other_y));
				if (angle.degenerate !== c.want.degenerate)
					report_mismatch($sformatf("degenerate %0b want %0b for (%0d,%0d)->(%0d,%0d)",
						angle.degenerate, c.want.degenerate, c.src.ref_x, c.src.ref_y,
						c.src.other_x, c.src.other_y));
			end
		end
		angle_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_pairs(0, 0, 190);
		test_random_pairs(52, 0, 190);
		test_drain_pause();
		test_random_pairs(0, 52, 190);
		test_random_pairs(13, 13, 190);
		idle_sender();
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> clockwise_angle_between_vectors.f
rtl/cabv_pkg.sv
rtl/clockwise_angle_between_vectors.sv
tb/sv/tb_clockwise_angle_between_vectors.sv
